// ----- hdl/rlpq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpq_pkg
// Shared types and constants of the token-bucket gated priority queue.
// ---------------------------------------------------------------------------
package rlpq_pkg;

    localparam int QUEUE_DEPTH         = 8;
    localparam int SLOT_W              = $clog2(QUEUE_DEPTH);
    localparam int CNT_W               = $clog2(QUEUE_DEPTH + 1);
    localparam int TOKEN_FRACTION_BITS = 24;
    localparam int TOK_W               = 40;
    localparam int TIME_W              = 48;
    localparam int RATE_W              = 32;
    localparam int BURST_W             = 16;

    localparam logic [31:0] RATE_RST   = 32'd16777;
    localparam logic [15:0] BURST_RST  = 16'd10;

    // Configuration register indexes
    localparam logic [1:0] REG_RATE     = 2'd0;
    localparam logic [1:0] REG_BURST    = 2'd1;
    localparam logic [1:0] REG_HEADROOM = 2'd2;

    typedef enum logic [1:0] {
        OP_SUBMIT   = 2'd0,
        OP_WITHDRAW = 2'd1,
        OP_PUMP     = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RK_INSERTED  = 3'd0,
        RK_COALESCED = 3'd1,
        RK_FULL      = 3'd2,
        RK_WITHDRAWN = 3'd3,
        RK_NOTFOUND  = 3'd4,
        RK_DISPATCH  = 3'd5,
        RK_DONE      = 3'd6,
        RK_TOKENS    = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_SUBMIT_WR,
        ST_REFILL_SUB,
        ST_REFILL_LO,
        ST_REFILL_HI,
        ST_REFILL_ADD,
        ST_PUMP_SCAN,
        ST_PUMP_LAST,
        ST_PUMP_DISP,
        ST_PUMP_WAIT,
        ST_EMIT
    } t_state;

    // One stored entry, 97 bits
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] prio;
        logic [31:0] seq;
        logic        has_label;
        logic [15:0] label;
    } t_entry;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] name;
        logic        is_label;
        logic [3:0]  count;
        logic [39:0] tokens;
        logic        last;
    } t_result;

    // Memory access from the controller
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_entry            wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } t_mem_req;

endpackage

// ----- hdl/rate_limited_priority_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rate_limited_priority_queue
// Keyed pending queue of eight entries behind a token bucket.
// ---------------------------------------------------------------------------
// One item at a time. Submit and withdraw scan the entry RAM one slot a cycle.
// Query runs the refill (elapsed time, low and high product halves, saturating
// add) and then emits. Pump on an empty queue goes straight to the done result,
// without a refill. Pump with entries runs the refill, then one selection round
// per dispatched entry plus a final round that ends in the done result; each
// round is a best-entry scan through the single RAM read port. A stalled result
// output stretches every step that emits. The output register frees the input
// side once a result has been taken.
module rate_limited_priority_queue
    import rlpq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] opcode, [49:2] now_ticks, [81:50] entry_key, [97:82] entry_priority,
    // [113:98] label_tag, [114] label_present, zero fill to 120
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] result_kind, [34:3] dispatch_name, [35] dispatch_is_label,
    // [39:36] dispatch_count, [79:40] tokens_now, zero fill to 80
    output logic [79:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [RATE_W-1:0]  w_rate;
    logic [BURST_W-1:0] w_burst;
    logic [TOK_W-1:0]   w_headroom;
    logic               w_burst_wr;
    t_mem_req           w_mem;
    t_entry             w_rd;
    t_result            w_res;

    rlpq_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_rate(w_rate), .o_burst(w_burst), .o_headroom(w_headroom),
        .o_burst_wr(w_burst_wr)
    );

    rlpq_entry_ram u_ram (.i_clk, .i_req(w_mem), .o_rd_data(w_rd));

    rlpq_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_item_valid(s_axis_tvalid), .o_item_ready(s_axis_tready),
        .i_opcode(s_axis_tdata[1:0]), .i_now_ticks(s_axis_tdata[49:2]),
        .i_entry_key(s_axis_tdata[81:50]), .i_entry_priority(s_axis_tdata[97:82]),
        .i_label_tag(s_axis_tdata[113:98]), .i_label_present(s_axis_tdata[114]),
        .i_rate(w_rate), .i_burst(w_burst), .i_headroom(w_headroom),
        .i_burst_wr(w_burst_wr),
        .o_mem(w_mem), .i_rd_data(w_rd),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {w_res.tokens, w_res.count, w_res.is_label, w_res.name, w_res.kind};
    assign m_axis_tlast = w_res.last;

endmodule

// ----- hdl/rlpq_entry_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpq_entry_ram
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rlpq_entry_ram
    import rlpq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [QUEUE_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_req.rd_addr];
    end

endmodule

// ----- hdl/rlpq_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpq_ctrl
// Sequencer: scans the entry store one slot a cycle, runs the token bucket
// and produces results into a one-deep output register.
// ---------------------------------------------------------------------------
module rlpq_ctrl
    import rlpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item in
    input  logic                 i_item_valid,
    output logic                 o_item_ready,
    input  logic [1:0]           i_opcode,
    input  logic [TIME_W-1:0]    i_now_ticks,
    input  logic [31:0]          i_entry_key,
    input  logic [15:0]          i_entry_priority,
    input  logic [15:0]          i_label_tag,
    input  logic                 i_label_present,
    // config
    input  logic [RATE_W-1:0]    i_rate,
    input  logic [BURST_W-1:0]   i_burst,
    input  logic [TOK_W-1:0]     i_headroom,
    input  logic                 i_burst_wr,
    // memory
    output t_mem_req             o_mem,
    input  t_entry               i_rd_data,
    // result out
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    localparam logic [TOK_W-1:0] ONE_TOKEN = TOK_W'(1) << TOKEN_FRACTION_BITS;
    localparam int HALF_T = TIME_W / 2;

    t_state r_state, n_state;
    logic [QUEUE_DEPTH-1:0] r_valid, n_valid;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]  r_ndisp, n_ndisp;
    logic [31:0]       r_seq, n_seq;
    logic [TOK_W-1:0]  r_tokens, n_tokens;
    logic [TIME_W-1:0] r_last_t, n_last_t;
    // current item
    t_op               r_op, n_op;
    logic [TIME_W-1:0] r_now, n_now;
    t_entry            r_item, n_item;
    // scan results
    logic              r_hit, n_hit;
    logic [SLOT_W-1:0] r_hit_slot, n_hit_slot;
    logic              r_best_ok, n_best_ok;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [15:0]       r_best_prio, n_best_prio;
    logic [31:0]       r_best_seq, n_best_seq;
    t_entry            r_best_ent, n_best_ent;
    // refill: elapsed ticks and product
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic [79:0]       r_prod, n_prod;
    // output register
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;

    logic [SLOT_W-1:0] r_rd_slot;
    logic [TOK_W-1:0]  w_cap;
    logic              w_free_ok;
    logic [SLOT_W-1:0] w_free;
    logic              w_out_free;
    logic              w_better;
    logic [HALF_T-1:0] w_mul_a;
    logic [HALF_T+RATE_W-1:0] w_part;

    assign w_cap = TOK_W'(i_burst) << TOKEN_FRACTION_BITS;
    assign w_out_free = !r_res_valid || i_res_ready;

    // one shared multiplier: low half of elapsed, then high half
    assign w_mul_a = (r_state == ST_REFILL_HI) ? r_elapsed[TIME_W-1:HALF_T]
                                               : r_elapsed[HALF_T-1:0];
    assign w_part  = w_mul_a * i_rate;

    // lowest free slot
    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_ok = 1'b1;
                w_free    = SLOT_W'(i);
            end
        end
    end

    // candidate from memory better than current best
    assign w_better = !r_best_ok
        || ($signed(i_rd_data.prio) < $signed(r_best_prio))
        || (i_rd_data.prio == r_best_prio && i_rd_data.seq < r_best_seq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_seq       <= '0;
            r_tokens    <= TOK_W'(BURST_RST) << TOKEN_FRACTION_BITS;
            r_last_t    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_seq       <= n_seq;
            r_tokens    <= i_burst_wr ? w_cap : n_tokens;
            r_last_t    <= n_last_t;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rd_slot   <= r_idx;
        r_ndisp     <= n_ndisp;
        r_op        <= n_op;
        r_now       <= n_now;
        r_item      <= n_item;
        r_hit       <= n_hit;
        r_hit_slot  <= n_hit_slot;
        r_best_ok   <= n_best_ok;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_best_seq  <= n_best_seq;
        r_best_ent  <= n_best_ent;
        r_elapsed   <= n_elapsed;
        r_prod      <= n_prod;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_ndisp     = r_ndisp;
        n_seq       = r_seq;
        n_tokens    = r_tokens;
        n_last_t    = r_last_t;
        n_op        = r_op;
        n_now       = r_now;
        n_item      = r_item;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_best_ok   = r_best_ok;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_best_seq  = r_best_seq;
        n_best_ent  = r_best_ent;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        o_item_ready = 1'b0;
        o_mem = '0;
        o_mem.rd_addr = r_idx;

        case (r_state)
            ST_IDLE: begin
                o_item_ready = w_out_free;
                if (i_item_valid && w_out_free) begin
                    n_op   = t_op'(i_opcode);
                    n_now  = i_now_ticks;
                    n_item = '{key: i_entry_key, prio: i_entry_priority, seq: r_seq + 32'd1,
                               has_label: i_label_present, label: i_label_tag};
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_best_ok = 1'b0;
                    n_ndisp = '0;
                    o_mem.rd_addr = '0;
                    case (t_op'(i_opcode))
                        OP_SUBMIT: begin
                            n_seq   = r_seq + 32'd1;
                            n_state = ST_SCAN;
                        end
                        OP_WITHDRAW: n_state = ST_SCAN;
                        OP_PUMP: n_state = (r_valid != '0) ? ST_REFILL_SUB : ST_EMIT;
                        default: n_state = ST_REFILL_SUB;
                    endcase
                end
            end

            // key search: read issued for r_idx, data of r_rd_slot arrives
            ST_SCAN: begin
                if (r_idx != SLOT_W'(QUEUE_DEPTH - 1)) begin
                    n_idx = r_idx + SLOT_W'(1);
                end else begin
                    n_state = ST_SCAN_LAST;
                end
                if (r_idx != '0 && r_valid[r_rd_slot] && !r_hit
                    && i_rd_data.key == r_item.key) begin
                    n_hit = 1'b1;
                    n_hit_slot = r_rd_slot;
                end
                if (QUEUE_DEPTH == 1) n_state = ST_SCAN_LAST;
            end

            ST_SCAN_LAST: begin
                if (r_valid[r_rd_slot] && !r_hit && i_rd_data.key == r_item.key) begin
                    n_hit = 1'b1;
                    n_hit_slot = r_rd_slot;
                end
                n_state = ST_SUBMIT_WR;
            end

            ST_SUBMIT_WR: begin
                if (w_out_free) begin
                    n_res = '0;
                    n_res.last = 1'b1;
                    n_res_valid = 1'b1;
                    n_state = ST_IDLE;
                    if (r_op == OP_WITHDRAW) begin
                        n_res.kind = r_hit ? RK_WITHDRAWN : RK_NOTFOUND;
                        if (r_hit) n_valid[r_hit_slot] = 1'b0;
                    end else if (r_hit) begin
                        n_res.kind = RK_COALESCED;
                        o_mem.wr_en = 1'b1;
                        o_mem.wr_addr = r_hit_slot;
                        o_mem.wr_data = r_item;
                    end else if (w_free_ok) begin
                        n_res.kind = RK_INSERTED;
                        o_mem.wr_en = 1'b1;
                        o_mem.wr_addr = w_free;
                        o_mem.wr_data = r_item;
                        n_valid[w_free] = 1'b1;
                    end else begin
                        n_res.kind = RK_FULL;
                    end
                end
            end

            // refill: elapsed time, product in two halves, saturating add
            ST_REFILL_SUB: begin
                n_elapsed = (r_now > r_last_t) ? (r_now - r_last_t) : '0;
                n_last_t = r_now;
                n_state = ST_REFILL_LO;
            end

            ST_REFILL_LO: begin
                n_prod = 80'(w_part);
                n_state = ST_REFILL_HI;
            end

            ST_REFILL_HI: begin
                n_prod = r_prod + {w_part, HALF_T'(0)};
                n_state = ST_REFILL_ADD;
            end

            ST_REFILL_ADD: begin
                if (r_tokens >= w_cap) n_tokens = w_cap;
                else if (r_prod > 80'(w_cap - r_tokens)) n_tokens = w_cap;
                else n_tokens = r_tokens + r_prod[TOK_W-1:0];
                if (r_op == OP_QUERY) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx = '0;
                    n_best_ok = 1'b0;
                    o_mem.rd_addr = '0;
                    n_state = ST_PUMP_SCAN;
                end
            end

            // best-entry search
            ST_PUMP_SCAN: begin
                if (r_idx != SLOT_W'(QUEUE_DEPTH - 1)) n_idx = r_idx + SLOT_W'(1);
                else n_state = ST_PUMP_LAST;
                if (QUEUE_DEPTH == 1) n_state = ST_PUMP_LAST;
                if (r_idx != '0 && r_valid[r_rd_slot] && w_better) begin
                    n_best_ok = 1'b1;
                    n_best = r_rd_slot;
                    n_best_prio = i_rd_data.prio;
                    n_best_seq = i_rd_data.seq;
                    n_best_ent = i_rd_data;
                end
            end

            ST_PUMP_LAST: begin
                if (r_valid[r_rd_slot] && w_better) begin
                    n_best_ok = 1'b1;
                    n_best = r_rd_slot;
                    n_best_prio = i_rd_data.prio;
                    n_best_seq = i_rd_data.seq;
                    n_best_ent = i_rd_data;
                end
                n_state = ST_PUMP_DISP;
            end

            ST_PUMP_DISP: begin
                if (!r_best_ok || ({1'b0, r_tokens} < ({1'b0, i_headroom} + {1'b0, ONE_TOKEN}))
                    || r_ndisp == CNT_W'(QUEUE_DEPTH)) begin
                    n_state = ST_EMIT;
                end else if (w_out_free) begin
                    n_tokens = r_tokens - ONE_TOKEN;
                    n_valid[r_best] = 1'b0;
                    n_ndisp = r_ndisp + CNT_W'(1);
                    n_res = '0;
                    n_res.kind = RK_DISPATCH;
                    n_res.is_label = r_best_ent.has_label;
                    n_res.name = r_best_ent.has_label ? {16'd0, r_best_ent.label}
                                                      : r_best_ent.key;
                    n_res.tokens = r_tokens - ONE_TOKEN;
                    n_res_valid = 1'b1;
                    n_state = ST_PUMP_WAIT;
                end
            end

            ST_PUMP_WAIT: begin
                n_idx = '0;
                n_best_ok = 1'b0;
                o_mem.rd_addr = '0;
                n_state = ST_PUMP_SCAN;
            end

            ST_EMIT: begin
                if (w_out_free) begin
                    n_res = '0;
                    n_res.kind = (r_op == OP_QUERY) ? RK_TOKENS : RK_DONE;
                    n_res.count = (r_op == OP_QUERY) ? 4'd0 : 4'(r_ndisp);
                    n_res.tokens = r_tokens;
                    n_res.last = 1'b1;
                    n_res_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

endmodule

// ----- hdl/rlpq_cfg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpq_cfg
// APB register file: rate, burst and headroom.
// ---------------------------------------------------------------------------
module rlpq_cfg
    import rlpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output logic [RATE_W-1:0]  o_rate,
    output logic [BURST_W-1:0] o_burst,
    output logic [TOK_W-1:0]   o_headroom,
    output logic               o_burst_wr
);

    logic [RATE_W-1:0]  r_rate;
    logic [BURST_W-1:0] r_burst;
    logic [TOK_W-1:0]   r_headroom;
    logic               r_burst_wr;
    logic               w_wr;
    logic [1:0]         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:3];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= RATE_RST;
            r_burst    <= BURST_RST;
            r_headroom <= '0;
        end else if (w_wr && paddr[2:0] == 3'd0) begin
            case (w_idx)
                REG_RATE:     r_rate     <= pwdata[RATE_W-1:0];
                REG_BURST:    r_burst    <= pwdata[BURST_W-1:0];
                REG_HEADROOM: r_headroom <= pwdata[TOK_W-1:0];
                default: ;
            endcase
        end
    end

    // bucket reload strobe, registered in the same cycle as the new burst value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_wr <= 1'b0;
        end else begin
            r_burst_wr <= w_wr && paddr[2:0] == 3'd0 && w_idx == REG_BURST;
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_RATE:     prdata = 64'(r_rate);
            REG_BURST:    prdata = 64'(r_burst);
            REG_HEADROOM: prdata = 64'(r_headroom);
            default:      prdata = '0;
        endcase
    end

    assign o_rate = r_rate;
    assign o_burst = r_burst;
    assign o_headroom = r_headroom;
    assign o_burst_wr = r_burst_wr;

endmodule

// ----- hdl/rlpq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlpq_checker
// Port-level checks of the queue, bound to the top level.
// ---------------------------------------------------------------------------
module rlpq_checker
    import rlpq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // results ending an item carry a closing kind
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] != RK_DISPATCH)
        else $error("dispatch marked last");

    a_notlast_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2:0] == RK_DISPATCH)
        else $error("closing kind not marked last");

    // an item accepted is not followed at once by another
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two items back to back");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind rate_limited_priority_queue rlpq_checker u_rlpq_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .pready
);

// ----- tb/rate_limited_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rate_limited_priority_queue_tb
// Self-checking bench for the token-bucket gated priority queue.
// ---------------------------------------------------------------------------
// Requests go in on the slave stream and registers are set over APB. A
// scoreboard class keeps its own copy of the slots, sequence counter and
// bucket. It queues the expected results of every accepted request and
// checks each result transfer against the oldest one. Both stream sides
// stall at random. A directed opening is followed by random phases under
// several bucket settings, the extremes among them.
// ---------------------------------------------------------------------------

import rlpq_pkg::*;

class queue_scoreboard;

    // Register copies
    int unsigned       rate;
    logic [15:0]       burst;
    longint unsigned   headroom;

    // Slot copies
    bit                slot_used  [QUEUE_DEPTH];
    int unsigned       slot_key   [QUEUE_DEPTH];
    shortint           slot_prio  [QUEUE_DEPTH];
    int unsigned       slot_seq   [QUEUE_DEPTH];
    bit                slot_has_lb[QUEUE_DEPTH];
    logic [15:0]       slot_label [QUEUE_DEPTH];

    int unsigned       seq_count;
    longint unsigned   level;
    longint unsigned   refill_stamp;

    t_result           pending_q[$];
    int                mismatches;
    int                results_seen;
    int                dispatches_seen;

    function new();
        rate = 16777;
        burst = 16'd10;
        headroom = 0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        seq_count = 0;
        level = longint'(burst) << TOKEN_FRACTION_BITS;
        refill_stamp = 0;
        mismatches = 0;
        results_seen = 0;
        dispatches_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
        case (idx)
            REG_RATE: begin
                rate = value[31:0];
            end
            REG_BURST: begin
                burst = value[15:0];
                level = longint'(burst) << TOKEN_FRACTION_BITS;
            end
            REG_HEADROOM: begin
                headroom = value[39:0];
            end
            default: ;
        endcase
    endfunction

    // Bucket refill up to capacity; the stamp follows now even backwards
    function void refill(longint unsigned now);
        longint unsigned cap;
        longint unsigned elapsed;
        longint unsigned room;
        cap = longint'(burst) << TOKEN_FRACTION_BITS;
        elapsed = (now > refill_stamp) ? now - refill_stamp : 0;
        if (level >= cap) begin
            level = cap;
        end else begin
            room = cap - level;
            if (rate != 0 && elapsed > room / rate)
                level = cap;
            else
                level = level + elapsed * rate;
        end
        refill_stamp = now;
    endfunction

    function void expect_result(t_kind kind, logic [31:0] name, bit is_lb,
                                logic [3:0] count, longint unsigned tokens, bit last);
        t_result r;
        r.kind = kind;
        r.name = name;
        r.is_label = is_lb;
        r.count = count;
        r.tokens = tokens[39:0];
        r.last = last;
        pending_q.insert(pending_q.size(), r);
    endfunction

    // Accepted request: update state and queue its results
    function void note_request(t_op op, logic [47:0] now, logic [31:0] key,
                               logic [15:0] prio, logic [15:0] tag, bit has_lb);
        int free_slot;
        int best;
        int n;
        bit any;
        longint unsigned one;
        one = longint'(1) << TOKEN_FRACTION_BITS;
        case (op)
            OP_SUBMIT: begin
                seq_count = seq_count + 1;
                free_slot = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i] && slot_key[i] == key) begin
                        slot_prio[i] = prio;
                        slot_seq[i] = seq_count;
                        slot_has_lb[i] = has_lb;
                        slot_label[i] = tag;
                        expect_result(RK_COALESCED, 0, 0, 0, 0, 1);
                        return;
                    end
                    if (!slot_used[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot < 0) begin
                    expect_result(RK_FULL, 0, 0, 0, 0, 1);
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot] = key;
                    slot_prio[free_slot] = prio;
                    slot_seq[free_slot] = seq_count;
                    slot_has_lb[free_slot] = has_lb;
                    slot_label[free_slot] = tag;
                    expect_result(RK_INSERTED, 0, 0, 0, 0, 1);
                end
            end
            OP_WITHDRAW: begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i] && slot_key[i] == key) begin
                        slot_used[i] = 1'b0;
                        expect_result(RK_WITHDRAWN, 0, 0, 0, 0, 1);
                        return;
                    end
                end
                expect_result(RK_NOTFOUND, 0, 0, 0, 0, 1);
            end
            OP_PUMP: begin
                n = 0;
                any = 0;
                foreach (slot_used[i]) if (slot_used[i]) any = 1;
                // An empty queue leaves the bucket untouched
                if (any) refill(now);
                while (n < QUEUE_DEPTH) begin
                    best = -1;
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (!slot_used[i]) continue;
                        if (best < 0 || slot_prio[i] < slot_prio[best] ||
                            (slot_prio[i] == slot_prio[best] && slot_seq[i] < slot_seq[best]))
                            best = i;
                    end
                    if (best < 0 || level < headroom + one) break;
                    level = level - one;
                    slot_used[best] = 1'b0;
                    if (slot_has_lb[best])
                        expect_result(RK_DISPATCH, {16'd0, slot_label[best]}, 1, 0, level, 0);
                    else
                        expect_result(RK_DISPATCH, slot_key[best], 0, 0, level, 0);
                    n++;
                end
                expect_result(RK_DONE, 0, 0, n[3:0], level, 1);
            end
            default: begin
                refill(now);
                expect_result(RK_TOKENS, 0, 0, 0, level, 1);
            end
        endcase
    endfunction

    // Result transfer against the oldest expectation
    function void check_result(logic [79:0] data, bit last);
        t_result got;
        t_result want;
        got.kind = data[2:0];
        got.name = data[34:3];
        got.is_label = data[35];
        got.count = data[39:36];
        got.tokens = data[79:40];
        got.last = last;
        results_seen++;
        if (got.kind == RK_DISPATCH) dispatches_seen++;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result kind=%0d name=%h", got.kind, got.name);
            return;
        end
        want = pending_q.pop_front();
        if (got.kind != want.kind || got.name != want.name ||
            got.is_label != want.is_label || got.count != want.count ||
            got.tokens != want.tokens || got.last != want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d exp kind=%0d name=%h lb=%0d cnt=%0d tok=%h last=%0d",
                         results_seen, want.kind, want.name, want.is_label, want.count,
                         want.tokens, want.last,
                         ", got kind=%0d name=%h lb=%0d cnt=%0d tok=%h last=%0d",
                         got.kind, got.name, got.is_label, got.count, got.tokens, got.last);
        end
    endfunction
endclass

module rate_limited_priority_queue_tb;
    import rlpq_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [1:0] opcode, [49:2] now_ticks, [81:50] entry_key, [97:82] entry_priority,
    // [113:98] label_tag, [114] label_present
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [2:0] result_kind, [34:3] dispatch_name, [35] dispatch_is_label,
    // [39:36] dispatch_count, [79:40] tokens_now
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    queue_scoreboard sb;
    bit              stalls_on;
    int              sink_stall;
    int              requests_sent;
    logic [47:0]     tick_now;
    logic [31:0]     key_pool[16];

    rate_limited_priority_queue u_top (.*);

    // 50 MHz clock, first rising edge after reset is applied
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Result sink with random backpressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall > 0) begin
                m_axis_tready = 1'b0;
                sink_stall--;
            end else begin
                m_axis_tready = i_rst_n;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
            sink_stall = stalls_on ? $urandom_range(0, 11) : 0;
        end
    end

    // APB register write: setup then access
    task automatic reg_write(logic [1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // One request transfer, with a random lead-in gap
    task automatic send_request(t_op op, logic [47:0] now, logic [31:0] key,
                                logic [15:0] prio, logic [15:0] tag, bit has_lb);
        int gap;
        gap = stalls_on ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tdata = {5'd0, has_lb, tag, prio, key, now, op};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, now, key, prio, tag, has_lb);
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_request();
        int          sel;
        logic [31:0] key;
        t_op         op;
        sel = $urandom_range(0, 99);
        op = sel < 45 ? OP_SUBMIT : sel < 60 ? OP_WITHDRAW : sel < 85 ? OP_PUMP : OP_QUERY;
        key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
        if ($urandom_range(0, 19) == 0)
            tick_now = 48'({$urandom, $urandom});
        else
            tick_now = tick_now + 48'($urandom_range(0, 3000));
        send_request(op, tick_now, key, 16'($urandom), 16'($urandom),
                     1'($urandom_range(0, 1)));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sink_stall = 0;
        stalls_on = 1'b1;
        requests_sent = 0;
        tick_now = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, coalescing, full queue, misses, tie order
        send_request(OP_PUMP, 48'd0, 32'd0, 16'd0, 16'd0, 0);          // empty pump
        send_request(OP_SUBMIT, 48'd0, 32'h0, 16'h8000, 16'hFFFF, 1);
        send_request(OP_SUBMIT, 48'd0, 32'hFFFF_FFFF, 16'h7FFF, 16'h0, 0);
        send_request(OP_SUBMIT, 48'd0, 32'h0, 16'h0000, 16'h1234, 0);  // coalesce
        send_request(OP_WITHDRAW, 48'd0, 32'h5, 16'd0, 16'd0, 0);      // miss
        send_request(OP_WITHDRAW, 48'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 0);
        for (int i = 1; i <= 7; i++)
            send_request(OP_SUBMIT, 48'd0, i, 16'h0005, 16'(16'hA500 + i), i[0]);
        send_request(OP_SUBMIT, 48'd0, 32'h99, 16'h0001, 16'd0, 0);    // full, dropped
        send_request(OP_PUMP, 48'd0, 32'd0, 16'd0, 16'd0, 0);          // drains all eight
        send_request(OP_QUERY, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd0, 16'd0, 0);
        send_request(OP_QUERY, 48'd5, 32'd0, 16'd0, 16'd0, 0);         // time backwards
        send_request(OP_SUBMIT, 48'd5, 32'h10, 16'hFFFF, 16'd0, 0);
        send_request(OP_SUBMIT, 48'd5, 32'h11, 16'hFFFF, 16'd0, 0);
        send_request(OP_SUBMIT, 48'd5, 32'h10, 16'hFFFF, 16'd7, 1);    // reorders by seq
        send_request(OP_PUMP, 48'd100, 32'd0, 16'd0, 16'd0, 0);
        drain();

        // Random phases over several bucket settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_RATE, 64'd16777);
                    reg_write(REG_BURST, 64'd10);
                    reg_write(REG_HEADROOM, 64'd0);
                end
                1: begin
                    reg_write(REG_RATE, 64'd0);
                    reg_write(REG_BURST, 64'd1);
                end
                2: begin
                    reg_write(REG_RATE, 64'hFFFF_FFFF);
                    reg_write(REG_BURST, 64'd65535);
                    reg_write(REG_HEADROOM, 64'hFF_FFFF_FFFF);
                end
                3: begin
                    reg_write(REG_RATE, 64'd1 << 24);
                    reg_write(REG_BURST, 64'd3);
                    reg_write(REG_HEADROOM, 64'd1 << 24);
                end
                default: begin
                    reg_write(REG_RATE, 64'd50000);
                    reg_write(REG_BURST, 64'd6);
                    reg_write(REG_HEADROOM, 64'h80_0000);
                end
            endcase
            tick_now = {16'($urandom_range(0, 3)), 32'd0};
            // last phase runs back to back on both sides
            stalls_on = (phase != 4);
            for (int n = 0; n < 28; n++) begin
                random_request();
                // hold off once until every pending result is back
                if (phase == 1 && n == 15) drain();
            end
            drain();
        end

        $display("Sent %0d requests under five bucket settings; checked %0d results, %0d dispatches.",
                 requests_sent, sb.results_seen, sb.dispatches_seen);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching results", sb.mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rlpq_pkg.sv
hdl/rlpq_entry_ram.sv
hdl/rlpq_ctrl.sv
hdl/rlpq_cfg.sv
hdl/rate_limited_priority_queue.sv
hdl/rlpq_checker.sv
tb/rate_limited_priority_queue_tb.sv
